// ===== rtl/assert_macros.svh =====
// Assertion macros included by the scheduler top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is active.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that is also evaluated during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tts_pkg.sv =====
`default_nettype none

package tts_pkg;

    // Operation codes.
    localparam logic [2:0] OP_CREATE   = 3'd0;
    localparam logic [2:0] OP_SCHEDULE = 3'd1;
    localparam logic [2:0] OP_SLEEP    = 3'd2;
    localparam logic [2:0] OP_WAKEUP   = 3'd3;
    localparam logic [2:0] OP_BLOCK    = 3'd4;
    localparam logic [2:0] OP_UNBLOCK  = 3'd5;

    // Task mode codes.
    localparam logic [2:0] MODE_INIT     = 3'd0;
    localparam logic [2:0] MODE_RUNNING  = 3'd1;
    localparam logic [2:0] MODE_READY    = 3'd2;
    localparam logic [2:0] MODE_BLOCKED  = 3'd3;
    localparam logic [2:0] MODE_SLEEPING = 3'd4;
    localparam logic [2:0] MODE_WAITING  = 3'd5;

    // Fault codes.
    localparam logic [1:0] FAULT_OK      = 2'd0;
    localparam logic [1:0] FAULT_FULL    = 2'd1;
    localparam logic [1:0] FAULT_ILLEGAL = 2'd2;

    // Configuration register byte addresses.
    localparam logic [2:0] ADDR_TICK_PERIOD = 3'd0;
    localparam logic [2:0] ADDR_IDLE_SLOT   = 3'd4;

    // One input item.
    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  task_index;
        logic [7:0]  priority_req;
        logic [19:0] sleep_ms;
        logic [31:0] now_tick;
        logic        block_kind;
        logic [7:0]  reason;
    } in_t;

    // One result item.
    typedef struct packed {
        logic [3:0] result_task;
        logic       switched;
        logic [1:0] fault;
        logic [7:0] status_out;
        logic [4:0] woken_count;
    } out_t;

    // Contents of one slot as seen by the controller.
    typedef struct packed {
        logic        used;
        logic [2:0]  mode;
        logic [31:0] ticks;
        logic [7:0]  prio;
        logic [7:0]  status;
    } slot_view_t;

    // Write command broadcast to the slot cells.
    typedef struct packed {
        logic        create;
        logic [7:0]  prio;
        logic        we_mode;
        logic [2:0]  mode;
        logic        we_ticks;
        logic [31:0] ticks;
        logic        we_status;
        logic [7:0]  status;
    } slot_cmd_t;

    // A task is parked while blocked, sleeping or waiting.
    function automatic logic is_parked(input logic [2:0] mode);
        return (mode == MODE_BLOCKED) || (mode == MODE_SLEEPING) || (mode == MODE_WAITING);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tts_cell.sv =====
`default_nettype none

module tts_cell #(
    parameter int TASK_SLOTS = 16,
    parameter int SLOT       = 0
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   sel,
    input  wire tts_pkg::slot_cmd_t                     cmd,
    input  wire logic [$clog2(TASK_SLOTS)-1:0]          cur,
    input  wire logic [31:0]                            now,
    input  wire logic [$clog2(TASK_SLOTS)+$clog2(TASK_SLOTS+1)*1+$clog2(TASK_SLOTS)+36-1:0] tok_in,
    output logic [$clog2(TASK_SLOTS)+$clog2(TASK_SLOTS+1)*1+$clog2(TASK_SLOTS)+36-1:0] tok_out,
    output tts_pkg::slot_view_t                         view
);

    localparam int IW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic          valid;
        logic          wake;
        logic          found;
        logic [IW-1:0] best;
        logic [31:0]   best_ticks;
        logic          free_found;
        logic [IW-1:0] free_idx;
        logic [CW-1:0] woken;
    } tok_t;

    tok_t tin;
    tok_t tout_next;
    tok_t tout_reg;

    logic        used_reg;
    logic [2:0]  mode_reg;
    logic [31:0] ticks_reg;
    logic [7:0]  prio_reg;
    logic [7:0]  status_reg;

    logic cand;
    logic wake_hit;

    assign tin     = tok_in;
    assign tok_out = tout_reg;
    assign view    = '{used: used_reg, mode: mode_reg, ticks: ticks_reg,
                       prio: prio_reg, status: status_reg};

    // Fold this slot into the passing token.
    always_comb
    begin
        cand = used_reg && (mode_reg == tts_pkg::MODE_READY) && (cur != IW'(SLOT));
        wake_hit = tin.valid && tin.wake && used_reg && (mode_reg == tts_pkg::MODE_SLEEPING)
                   && (ticks_reg <= now);
        tout_next = tin;
        if (cand && (!tin.found || (tin.best_ticks < ticks_reg)))
        begin
            tout_next.found      = 1'b1;
            tout_next.best       = IW'(SLOT);
            tout_next.best_ticks = ticks_reg;
        end
        if (!tin.free_found && !used_reg)
        begin
            tout_next.free_found = 1'b1;
            tout_next.free_idx   = IW'(SLOT);
        end
        if (wake_hit)
        begin
            tout_next.woken = tin.woken + CW'(1);
        end
    end

    // Token register handed to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tout_reg <= '0;
        end
        else
        begin
            tout_reg <= tout_next;
        end
    end

    // Slot state: broadcast writes and wakeup as the token passes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= 1'b0;
            mode_reg   <= tts_pkg::MODE_INIT;
            ticks_reg  <= '0;
            status_reg <= '0;
        end
        else if (wake_hit)
        begin
            mode_reg   <= tts_pkg::MODE_READY;
            ticks_reg  <= '0;
            status_reg <= '0;
        end
        else if (sel)
        begin
            if (cmd.create)
            begin
                used_reg   <= 1'b1;
                mode_reg   <= tts_pkg::MODE_READY;
                ticks_reg  <= 32'(cmd.prio);
                status_reg <= '0;
            end
            if (cmd.we_mode)
            begin
                mode_reg <= cmd.mode;
            end
            if (cmd.we_ticks)
            begin
                ticks_reg <= cmd.ticks;
            end
            if (cmd.we_status)
            begin
                status_reg <= cmd.status;
            end
        end
    end

    // Priority is written only by create.
    always_ff @(posedge clk)
    begin
        if (sel && cmd.create)
        begin
            prio_reg <= cmd.prio;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/task_table_scheduler_top.sv =====
`default_nettype none

// Task table and time-slice scheduler. Pulse start while busy is low to hand
// over one item; exactly one result follows, shown for a single cycle with
// done high, and it must be captured in that cycle since the block cannot
// be held off. The slots live in a row of cells that a scan token crosses,
// one cell per cycle; create, schedule and wakeup run one scan, sleep adds
// a bit-serial divide of the duration by the tick period before its scan,
// and block and unblock need no scan unless the running task blocks.
// The configuration registers sit on the APB port at byte 0 (tick period)
// and byte 4 (idle slot); the user must write them only while the block is
// idle, as the block itself does not enforce it.

`include "assert_macros.svh"

module task_table_scheduler_top #(
    parameter int TASK_SLOTS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire tts_pkg::in_t  item,
    output logic               done,
    output tts_pkg::out_t      result,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int TW = 2 * IW + CW + 36;

    typedef struct packed {
        logic          valid;
        logic          wake;
        logic          found;
        logic [IW-1:0] best;
        logic [31:0]   best_ticks;
        logic          free_found;
        logic [IW-1:0] free_idx;
        logic [CW-1:0] woken;
    } tok_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_SLEEPW = 8'b0000_1000,
        S_SCAN   = 8'b0001_0000,
        S_CUR    = 8'b0010_0000,
        S_NXT    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    tts_pkg::in_t       item_reg;
    tts_pkg::out_t      res_reg;
    logic [IW-1:0]      cur_reg;
    logic [IW-1:0]      nxt_reg;
    logic [9:0]         period_reg;
    logic [3:0]         idle_reg;
    logic [9:0]         rem_reg;
    logic [19:0]        quo_reg;
    logic [4:0]         cnt_reg;

    tok_t               tok_head;
    logic [TW-1:0]      tok_bits [TASK_SLOTS+1];
    tok_t               tok_last;
    tts_pkg::slot_view_t views [TASK_SLOTS];
    tts_pkg::slot_view_t rv;
    tts_pkg::slot_cmd_t  cmd;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      idx_s;
    logic               idx_ok;
    logic               launch;
    logic [9:0]         per;
    logic [10:0]        rem_sh;
    logic               div_ge;
    logic [19:0]        quo_min;
    logic [IW-1:0]      pick;
    logic               op_is_target;

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_OUT);
    assign pready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 10'd10;
            idle_reg   <= 4'd0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == tts_pkg::ADDR_IDLE_SLOT[2])
            begin
                idle_reg <= pwdata[3:0];
            end
            else
            begin
                period_reg <= pwdata[9:0];
            end
        end
    end

    assign prdata = (paddr[2] == tts_pkg::ADDR_IDLE_SLOT[2]) ? {28'd0, idle_reg}
                                                              : {22'd0, period_reg};

    // Row of slot cells with the scan token running through it.
    assign tok_bits[0] = tok_head;
    assign tok_last    = tok_bits[TASK_SLOTS];

    always_comb
    begin
        tok_head       = '0;
        tok_head.valid = launch;
        tok_head.wake  = (item_reg.operation == tts_pkg::OP_WAKEUP);
    end

    for (genvar g = 0; g < TASK_SLOTS; g++)
    begin : g_cell
        tts_cell #(
            .TASK_SLOTS (TASK_SLOTS),
            .SLOT       (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .sel     (wr_en && (wr_addr == IW'(g))),
            .cmd     (cmd),
            .cur     (cur_reg),
            .now     (item_reg.now_tick),
            .tok_in  (tok_bits[g]),
            .tok_out (tok_bits[g+1]),
            .view    (views[g])
        );
    end

    // Addressed slot and single read port.
    always_comb
    begin
        idx_s        = IW'(item_reg.task_index);
        idx_ok       = (int'(item_reg.task_index) < TASK_SLOTS);
        op_is_target = (item_reg.operation == tts_pkg::OP_BLOCK)
                       || (item_reg.operation == tts_pkg::OP_UNBLOCK);
        rd_addr      = (state_reg == S_DECODE && op_is_target) ? idx_s : cur_reg;
        rv           = views[rd_addr];
    end

    // Divider step and slot choice after a scan.
    always_comb
    begin
        per     = (period_reg == 10'd0) ? 10'd1 : period_reg;
        rem_sh  = {rem_reg, quo_reg[19]};
        div_ge  = (rem_sh >= {1'b0, per});
        quo_min = (quo_reg == 20'd0) ? 20'd1 : quo_reg;
        if (tok_last.found)
        begin
            pick = tok_last.best;
        end
        else if (int'(idle_reg) < TASK_SLOTS)
        begin
            pick = IW'(idle_reg);
        end
        else
        begin
            pick = cur_reg;
        end
    end

    // Write command, launch and next state.
    always_comb
    begin
        cmd        = '0;
        wr_en      = 1'b0;
        wr_addr    = cur_reg;
        launch     = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_OUT;
                case (item_reg.operation)
                    tts_pkg::OP_CREATE, tts_pkg::OP_SCHEDULE, tts_pkg::OP_WAKEUP:
                    begin
                        launch     = 1'b1;
                        state_next = S_SCAN;
                    end
                    tts_pkg::OP_SLEEP:
                    begin
                        if (rv.used)
                        begin
                            state_next = S_DIV;
                        end
                    end
                    tts_pkg::OP_BLOCK:
                    begin
                        if (idx_ok && rv.used && !tts_pkg::is_parked(rv.mode))
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = idx_s;
                            cmd.we_mode = 1'b1;
                            cmd.mode    = item_reg.block_kind ? tts_pkg::MODE_WAITING
                                                              : tts_pkg::MODE_BLOCKED;
                            if (idx_s == cur_reg)
                            begin
                                launch     = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                    end
                    tts_pkg::OP_UNBLOCK:
                    begin
                        if (idx_ok && rv.used && tts_pkg::is_parked(rv.mode))
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = idx_s;
                            cmd.we_mode   = 1'b1;
                            cmd.mode      = tts_pkg::MODE_READY;
                            cmd.we_status = 1'b1;
                            cmd.status    = item_reg.reason;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_DIV:
            begin
                if (cnt_reg == 5'd19)
                begin
                    state_next = S_SLEEPW;
                end
            end
            S_SLEEPW:
            begin
                wr_en        = 1'b1;
                cmd.we_ticks = 1'b1;
                cmd.ticks    = item_reg.now_tick + 32'(quo_min);
                cmd.we_mode  = 1'b1;
                cmd.mode     = tts_pkg::MODE_SLEEPING;
                launch       = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                if (tok_last.valid)
                begin
                    if (item_reg.operation == tts_pkg::OP_CREATE)
                    begin
                        wr_en      = tok_last.free_found;
                        wr_addr    = tok_last.free_idx;
                        cmd.create = 1'b1;
                        cmd.prio   = item_reg.priority_req;
                        state_next = S_OUT;
                    end
                    else if (item_reg.operation == tts_pkg::OP_WAKEUP)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_CUR;
                    end
                end
            end
            S_CUR:
            begin
                // Demote the old task and refill an empty slice.
                wr_en        = rv.used;
                cmd.we_mode  = (rv.mode == tts_pkg::MODE_RUNNING);
                cmd.mode     = tts_pkg::MODE_READY;
                cmd.we_ticks = (rv.ticks == 32'd0);
                cmd.ticks    = 32'(rv.prio);
                state_next   = S_NXT;
            end
            S_NXT:
            begin
                wr_en       = 1'b1;
                wr_addr     = nxt_reg;
                cmd.we_mode = 1'b1;
                cmd.mode    = tts_pkg::MODE_RUNNING;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DECODE)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
            if (state_reg == S_NXT)
            begin
                cur_reg <= nxt_reg;
            end
        end
    end

    // Item, divider and result registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            item_reg <= item;
        end
        case (state_reg)
            S_DECODE:
            begin
                res_reg <= '0;
                rem_reg <= '0;
                quo_reg <= item_reg.sleep_ms;
                case (item_reg.operation)
                    tts_pkg::OP_SLEEP:
                    begin
                        if (!rv.used)
                        begin
                            res_reg.fault <= tts_pkg::FAULT_ILLEGAL;
                        end
                    end
                    tts_pkg::OP_BLOCK:
                    begin
                        if (!idx_ok || !rv.used || tts_pkg::is_parked(rv.mode))
                        begin
                            res_reg.fault <= tts_pkg::FAULT_ILLEGAL;
                        end
                        else
                        begin
                            res_reg.status_out <= rv.status;
                        end
                    end
                    tts_pkg::OP_UNBLOCK:
                    begin
                        if (!idx_ok || !rv.used || !tts_pkg::is_parked(rv.mode))
                        begin
                            res_reg.fault <= tts_pkg::FAULT_ILLEGAL;
                        end
                        else
                        begin
                            res_reg.status_out <= item_reg.reason;
                        end
                    end
                    tts_pkg::OP_CREATE, tts_pkg::OP_SCHEDULE, tts_pkg::OP_WAKEUP:
                    begin
                        res_reg.fault <= tts_pkg::FAULT_OK;
                    end
                    default:
                    begin
                        res_reg.fault <= tts_pkg::FAULT_ILLEGAL;
                    end
                endcase
            end
            S_DIV:
            begin
                rem_reg <= div_ge ? 10'(rem_sh - {1'b0, per}) : rem_sh[9:0];
                quo_reg <= {quo_reg[18:0], div_ge};
            end
            S_SCAN:
            begin
                nxt_reg <= pick;
                if (tok_last.valid)
                begin
                    if (item_reg.operation == tts_pkg::OP_CREATE)
                    begin
                        if (tok_last.free_found)
                        begin
                            res_reg.result_task <= 4'(tok_last.free_idx);
                        end
                        else
                        begin
                            res_reg.fault <= tts_pkg::FAULT_FULL;
                        end
                    end
                    res_reg.woken_count <= 5'(tok_last.woken);
                end
            end
            S_NXT:
            begin
                res_reg.switched <= (nxt_reg != cur_reg);
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

    // Create reports its slot; every other operation the running slot.
    always_comb
    begin
        result = res_reg;
        if (item_reg.operation != tts_pkg::OP_CREATE)
        begin
            result.result_task = 4'(cur_reg);
        end
    end

    `ASSERT_CLK(a_done_single, done |=> !done, "done lasted more than one cycle")
    `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
    `ASSERT_CLK(a_full_create, (done && result.fault == tts_pkg::FAULT_FULL) |-> (item_reg.operation == tts_pkg::OP_CREATE), "table full on an operation other than create")
    `ASSERT_CLK(a_woken_wakeup, (done && result.woken_count != 5'd0) |-> (item_reg.operation == tts_pkg::OP_WAKEUP), "woken count on an operation other than wakeup")

endmodule

`default_nettype wire
